// ===== hw/rtl/tdr_pkg.sv =====
// types, constants and register codes of the trajectory decimating recorder
package tdr_pkg;

   localparam int DEPTH_DEF      = 4096;
   localparam int FRAME_BITS_DEF = 16;

   localparam int REQ_DATA_W  = 256;
   localparam int RSP_DATA_W  = 256;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [15:0] OVERRIDE_FRAME_RST = 16'd0;
   localparam logic [12:0] MAX_SAMPLES_RST    = 13'd4096;
   localparam logic [63:0] MIN_DIST_SQ_RST    = 64'd1718721;
   localparam logic [61:0] MIN_PERIOD_RST     = 62'd100000000;

   typedef enum logic [1:0] {
      CSR_OVERRIDE_FRAME = 2'd0,
      CSR_MAX_SAMPLES    = 2'd1,
      CSR_MIN_DIST_SQ    = 2'd2,
      CSR_MIN_PERIOD     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_START_EMPTY   = 3'd0,
      ST_START_FRAME   = 3'd1,
      ST_START_REVERSE = 3'd2,
      ST_APPENDED      = 3'd3,
      ST_REPLACED      = 3'd4,
      ST_READ_OK       = 3'd5,
      ST_READ_RANGE    = 3'd6
   } status_type;

   typedef enum logic {
      FUNC_SAMPLE = 1'b0,
      FUNC_READ   = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      SRC_SAMPLE = 2'd0,
      SRC_MEM    = 2'd1,
      SRC_ZERO   = 2'd2
   } out_src_type;

   // qx in the lowest bits
   typedef struct packed {
      logic [15:0] qw;
      logic [15:0] qz;
      logic [15:0] qy;
      logic [15:0] qx;
   } orient_type;

   // stamp in the lowest bits
   typedef struct packed {
      orient_type  orient;
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
      logic [61:0] stamp;
   } entry_type;

   typedef struct packed {
      logic [5:0]  pad;
      logic [11:0] read_pos;
      orient_type  quat;
      logic [31:0] pos_z;
      logic [31:0] pos_y;
      logic [31:0] pos_x;
      logic [61:0] stamp_ns;
      logic [15:0] frame_tag;
   } req_data_type;

   typedef struct packed {
      logic [4:0]  pad;
      entry_type   entry;
      logic [15:0] path_frame;
      logic [12:0] entry_count;
   } rsp_data_type;

endpackage

// ===== hw/rtl/trajectory_decimating_recorder_unit.sv =====
// top level of the trajectory decimating recorder: ring store of decimated poses
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------------
//  req     | in        | req_tvalid/req_tready | tuser: func; tdata: sample or read pos
//  rsp     | out       | rsp_tvalid/rsp_tready | tuser: status; tdata: count, frame, entry
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data (always ready)
//
// one request per cycle sustained while rsp is not stalled; a result is offered once its
// request has passed the request register, square stage, result register with the store read.
// the newest pose is kept in a register, so the store port is only read for read
// requests and written once per sample.
// reset clears the control state only; entries are undefined until written.
// a stalled rsp holds the result register; two more requests fill the pipeline
// behind it before req_tready drops. samples without a frame give no result.
module trajectory_decimating_recorder_unit #(
   parameter int DEPTH      = tdr_pkg::DEPTH_DEF,
   parameter int FRAME_BITS = tdr_pkg::FRAME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // frame_tag, stamp_ns, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, read_pos
   input  logic [tdr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // entry_count, path_frame, entry_stamp, entry_x, entry_y, entry_z,
   // entry_qx, entry_qy, entry_qz, entry_qw
   output logic [tdr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic [2:0]                        rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tdr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tdr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import tdr_pkg::*;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;

   function automatic logic [ADDR_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] r;
      r = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
      return r[ADDR_W-1:0];
   endfunction

   function automatic logic [63:0] sq_diff(input logic [31:0] a, input logic [31:0] b);
      logic signed [32:0] d;
      logic [32:0]        n;
      logic [31:0]        m;
      d = 33'($signed(a)) - 33'($signed(b));
      n = 33'(-d);
      m = d[32] ? n[31:0] : d[31:0];
      return 64'(m) * 64'(m);
   endfunction

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = 65'(a) + 65'(b);
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   // configuration
   logic [15:0] override_frame_ff, override_frame_in;
   logic [12:0] max_samples_ff, max_samples_in;
   logic [63:0] min_dist_sq_ff, min_dist_sq_in;
   logic [61:0] min_period_ff, min_period_in;

   // path state
   logic [ADDR_W-1:0]     oldest_ff, oldest_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [FRAME_BITS-1:0] cur_frame_ff, cur_frame_in;
   logic [61:0]           last_stamp_ff, last_stamp_in;
   logic [31:0]           last_x_ff, last_x_in;
   logic [31:0]           last_y_ff, last_y_in;
   logic [31:0]           last_z_ff, last_z_in;

   // request stage
   req_data_type          req_fields;
   logic                  req_go;
   logic                  s1_valid_ff, s1_valid_in;
   func_type              s1_func_ff, s1_func_in;
   logic [FRAME_BITS-1:0] s1_frame_ff, s1_frame_in;
   entry_type             s1_entry_ff, s1_entry_in;
   logic [11:0]           s1_pos_ff, s1_pos_in;
   logic                  s1_go;
   logic                  s1_drop;
   logic                  s1_keep;

   // square stage
   logic                  s2_valid_ff, s2_valid_in;
   func_type              s2_func_ff, s2_func_in;
   logic [FRAME_BITS-1:0] s2_frame_ff, s2_frame_in;
   entry_type             s2_entry_ff, s2_entry_in;
   logic [11:0]           s2_pos_ff, s2_pos_in;
   logic [63:0]           s2_sqx_ff, s2_sqx_in;
   logic [63:0]           s2_sqy_ff, s2_sqy_in;
   logic [63:0]           s2_sqz_ff, s2_sqz_in;
   logic                  s2_go;

   // decision
   logic [63:0]           dist_part;
   logic [63:0]           dist_total;
   logic [61:0]           dt;
   logic [31:0]           ms_wide;
   logic [CNT_W-1:0]      lim;
   logic                  take_step;
   logic                  restart;
   status_type            restart_status;
   logic [SUM_W-1:0]      cnt_next;
   logic [ADDR_W-1:0]     append_slot;
   logic [ADDR_W-1:0]     newest_slot;
   logic [ADDR_W-1:0]     trim_slot;
   logic [ADDR_W-1:0]     read_slot;
   logic                  read_hit;
   status_type            out_status;
   out_src_type           out_src;

   // store
   entry_type             store_mem [DEPTH];
   entry_type             rd_data_ff;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [15:0]           rsp_frame_ff, rsp_frame_in;
   out_src_type           rsp_src_ff, rsp_src_in;
   entry_type             rsp_entry_ff, rsp_entry_in;
   entry_type             rsp_entry_mux;
   rsp_data_type          rsp_fields;

   // configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      override_frame_in = override_frame_ff;
      max_samples_in    = max_samples_ff;
      min_dist_sq_in    = min_dist_sq_ff;
      min_period_in     = min_period_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_OVERRIDE_FRAME: override_frame_in = csr_data[15:0];
            CSR_MAX_SAMPLES:    max_samples_in    = csr_data[12:0];
            CSR_MIN_DIST_SQ:    min_dist_sq_in    = csr_data;
            CSR_MIN_PERIOD:     min_period_in     = csr_data[61:0];
         endcase
      end
   end

   // flow control
   assign s2_go      = s2_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign s1_go      = s1_valid_ff && (!s2_valid_ff || s2_go);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_go     = req_tvalid && req_tready;

   // request stage: frame resolved here; config must be stable while requests flow (the block does not enforce it)
   assign req_fields = req_data_type'(req_tdata);

   always_comb begin
      s1_valid_in        = req_go ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      s1_func_in         = func_type'(req_tuser);
      s1_frame_in        = (override_frame_ff != 16'd0) ? FRAME_BITS'(override_frame_ff)
                                                        : FRAME_BITS'(req_fields.frame_tag);
      s1_entry_in.stamp  = req_fields.stamp_ns;
      s1_entry_in.x      = req_fields.pos_x;
      s1_entry_in.y      = req_fields.pos_y;
      s1_entry_in.z      = req_fields.pos_z;
      s1_entry_in.orient = req_fields.quat;
      s1_pos_in          = req_fields.read_pos;
   end

   assign s1_drop = (s1_func_ff == FUNC_SAMPLE) && (s1_frame_ff == '0);
   assign s1_keep = s1_go && (s1_func_ff == FUNC_SAMPLE) && !s1_drop;

   // square stage: the newest stored pose is always the last kept sample
   always_comb begin
      s2_valid_in = (s1_go && !s1_drop) ? 1'b1 : (s2_go ? 1'b0 : s2_valid_ff);
      s2_func_in  = s1_func_ff;
      s2_frame_in = s1_frame_ff;
      s2_entry_in = s1_entry_ff;
      s2_pos_in   = s1_pos_ff;
      s2_sqx_in   = sq_diff(s1_entry_ff.x, last_x_ff);
      s2_sqy_in   = sq_diff(s1_entry_ff.y, last_y_ff);
      s2_sqz_in   = sq_diff(s1_entry_ff.z, last_z_ff);
      last_x_in   = s1_keep ? s1_entry_ff.x : last_x_ff;
      last_y_in   = s1_keep ? s1_entry_ff.y : last_y_ff;
      last_z_in   = s1_keep ? s1_entry_ff.z : last_z_ff;
   end

   // decision stage
   assign dist_part  = sat_add(s2_sqx_ff, s2_sqy_ff);
   assign dist_total = sat_add(dist_part, s2_sqz_ff);
   assign dt         = s2_entry_ff.stamp - last_stamp_ff;
   assign take_step  = (dist_total >= min_dist_sq_ff) || (dt >= min_period_ff);

   assign ms_wide = 32'(max_samples_ff);
   assign lim     = (ms_wide == 32'd0)           ? CNT_W'(1) :
                    (ms_wide > 32'(DEPTH))       ? CNT_W'(DEPTH) : CNT_W'(ms_wide);

   always_comb begin
      restart        = 1'b1;
      restart_status = ST_START_EMPTY;
      if (cur_frame_ff == '0) begin
         restart_status = ST_START_EMPTY;
      end else if (cur_frame_ff != s2_frame_ff) begin
         restart_status = ST_START_FRAME;
      end else if ((count_ff != '0) && (s2_entry_ff.stamp < last_stamp_ff)) begin
         restart_status = ST_START_REVERSE;
      end else if (count_ff != '0) begin
         restart = 1'b0;
      end
   end

   assign cnt_next    = SUM_W'(count_ff) + SUM_W'(1);
   assign append_slot = wrap_slot(SUM_W'(oldest_ff) + SUM_W'(count_ff));
   assign newest_slot = wrap_slot(SUM_W'(oldest_ff) + SUM_W'(count_ff) - SUM_W'(1));
   assign trim_slot   = wrap_slot(SUM_W'(oldest_ff) + (cnt_next - SUM_W'(lim)));
   assign read_hit    = 32'(s2_pos_ff) < 32'(count_ff);
   assign read_slot   = wrap_slot(SUM_W'(oldest_ff) + SUM_W'(s2_pos_ff));

   always_comb begin
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      cur_frame_in  = cur_frame_ff;
      last_stamp_in = last_stamp_ff;
      wr_en         = 1'b0;
      wr_addr       = oldest_ff;
      rd_en         = 1'b0;
      rd_addr       = read_slot;
      out_status    = ST_START_EMPTY;
      out_src       = SRC_SAMPLE;
      if (s2_go) begin
         if (s2_func_ff == FUNC_READ) begin
            if (read_hit) begin
               rd_en      = 1'b1;
               out_status = ST_READ_OK;
               out_src    = SRC_MEM;
            end else begin
               out_status = ST_READ_RANGE;
               out_src    = SRC_ZERO;
            end
         end else begin
            wr_en = 1'b1;
            if (restart) begin
               // new path starts at the current oldest slot
               cur_frame_in  = s2_frame_ff;
               count_in      = CNT_W'(1);
               last_stamp_in = s2_entry_ff.stamp;
               wr_addr       = oldest_ff;
               out_status    = restart_status;
            end else if (take_step) begin
               wr_addr       = append_slot;
               last_stamp_in = s2_entry_ff.stamp;
               out_status    = ST_APPENDED;
               if (cnt_next > SUM_W'(lim)) begin
                  // drop oldest entries down to the limit
                  oldest_in = trim_slot;
                  count_in  = lim;
               end else begin
                  count_in  = cnt_next[CNT_W-1:0];
               end
            end else begin
               wr_addr    = newest_slot;
               out_status = ST_REPLACED;
            end
         end
      end
   end

   // store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= s2_entry_ff;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = s2_go ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_status_in = out_status;
      rsp_count_in  = count_in;
      rsp_frame_in  = 16'(cur_frame_in);
      rsp_src_in    = out_src;
      rsp_entry_in  = s2_entry_ff;
   end

   always_comb begin
      case (rsp_src_ff)
         SRC_SAMPLE: rsp_entry_mux = rsp_entry_ff;
         SRC_MEM:    rsp_entry_mux = rd_data_ff;
         default:    rsp_entry_mux = '0;
      endcase
   end

   always_comb begin
      rsp_fields             = '0;
      rsp_fields.entry       = rsp_entry_mux;
      rsp_fields.path_frame  = rsp_frame_ff;
      rsp_fields.entry_count = 13'(rsp_count_ff);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_fields;
   assign rsp_tuser  = rsp_status_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         override_frame_ff <= OVERRIDE_FRAME_RST;
         max_samples_ff    <= MAX_SAMPLES_RST;
         min_dist_sq_ff    <= MIN_DIST_SQ_RST;
         min_period_ff     <= MIN_PERIOD_RST;
         oldest_ff         <= '0;
         count_ff          <= '0;
         cur_frame_ff      <= '0;
         last_stamp_ff     <= '0;
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         override_frame_ff <= override_frame_in;
         max_samples_ff    <= max_samples_in;
         min_dist_sq_ff    <= min_dist_sq_in;
         min_period_ff     <= min_period_in;
         oldest_ff         <= oldest_in;
         count_ff          <= count_in;
         cur_frame_ff      <= cur_frame_in;
         last_stamp_ff     <= last_stamp_in;
         s1_valid_ff       <= s1_valid_in;
         s2_valid_ff       <= s2_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_go) begin
         s1_func_ff  <= s1_func_in;
         s1_frame_ff <= s1_frame_in;
         s1_entry_ff <= s1_entry_in;
         s1_pos_ff   <= s1_pos_in;
      end
      if (s1_go) begin
         s2_func_ff  <= s2_func_in;
         s2_frame_ff <= s2_frame_in;
         s2_entry_ff <= s2_entry_in;
         s2_pos_ff   <= s2_pos_in;
         s2_sqx_ff   <= s2_sqx_in;
         s2_sqy_ff   <= s2_sqy_in;
         s2_sqz_ff   <= s2_sqz_in;
      end
      last_x_ff <= last_x_in;
      last_y_ff <= last_y_in;
      last_z_ff <= last_z_in;
      if (s2_go) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_frame_ff  <= rsp_frame_in;
         rsp_src_ff    <= rsp_src_in;
         rsp_entry_ff  <= rsp_entry_in;
      end
   end

   // an empty store and an unknown frame go together
   a_count_frame: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (cur_frame_ff == '0))
      else $error("store count and path frame disagree");

   // a committed sample leaves a nonempty path in its own frame
   a_sample_commit: assert property (@(posedge clock) disable iff (reset)
      (s2_go && (s2_func_ff == FUNC_SAMPLE)) |=>
         ((count_ff != '0) && (cur_frame_ff == $past(s2_frame_ff))))
      else $error("sample commit did not set up the path");

   // ring pointers stay inside the store
   a_ring_bounds: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) <= 32'(DEPTH)) && (32'(oldest_ff) < 32'(DEPTH)))
      else $error("ring pointer out of range");

endmodule
